### design/bounded_set_span_tracker_unit_macros.svh
// Assertion macros for the span tracker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BOUNDED_SET_SPAN_TRACKER_UNIT_MACROS_SVH
`define BOUNDED_SET_SPAN_TRACKER_UNIT_MACROS_SVH

// same-cycle implication
`define BSST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bsst_pkg.sv
// Package for the span tracker: payload types, state codes, gap function.
// No dependencies.
package bsst_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 1024;
  localparam int unsigned COUNT_W         = 11;
  localparam int unsigned VALUE_W         = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] stored_count;
    logic               spans_valid;
    logic [VALUE_W-1:0] shortest_span;
    logic [VALUE_W-1:0] longest_span;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] max_count;
  } cfg_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  function automatic logic [VALUE_W-1:0] abs_gap(
    input logic [VALUE_W-1:0] a,
    input logic [VALUE_W-1:0] b
  );
    if ($signed(a) < $signed(b)) begin
      return b - a;
    end else begin
      return a - b;
    end
  endfunction

endpackage

### design/bsst_chan_if.sv
// Valid/ready channel carrying one payload of type data_t.
// Payload types come from bsst_pkg.
interface bsst_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/bounded_set_span_tracker_unit.sv
// Flow: an accepted item with numbers held is scanned against every stored number,
// reading one stored number per cycle, before its result is registered; a refused
// item or the first number skips the scan. One item at a time: no new item is taken
// until the result is registered, and a result held by the receiver stalls the next.
// Reset: rst_n synchronous, active low; clears count, extremes, gap and capacity.
// Store contents are not cleared; only entries below the count are ever read.
`include "bounded_set_span_tracker_unit_macros.svh"

module bounded_set_span_tracker_unit #(
  parameter int unsigned MAX_ENTRIES = bsst_pkg::MAX_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bsst_chan_if.sink    in_if,
  bsst_chan_if.source  out_if,
  bsst_chan_if.sink    cfg_if
);

  localparam int unsigned AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW    = CNT_W + bsst_pkg::COUNT_W;
  localparam int unsigned VW    = bsst_pkg::VALUE_W;

  logic [VW-1:0] store_mem [MAX_ENTRIES];

  bsst_pkg::state_t state_r, state_nxt;

  logic [bsst_pkg::COUNT_W-1:0] max_count_r;
  logic [CNT_W-1:0]             held_r, held_nxt;
  logic [CNT_W-1:0]             scan_idx_r;
  logic [VW-1:0]                least_r, least_nxt;
  logic [VW-1:0]                greatest_r, greatest_nxt;
  logic [VW-1:0]                closest_r;
  logic [VW-1:0]                val_r;
  logic                         acc_r;
  logic [VW-1:0]                rdata_r;
  logic                         rd_vld_r;
  logic [VW-1:0]                gap_r;
  logic                         gap_vld_r;
  logic                         out_valid_r;
  bsst_pkg::out_item_t          out_data_r;
  bsst_pkg::out_item_t          out_data_nxt;

  logic [CW-1:0] cap;
  logic [CW-1:0] maxc_ext;
  logic [CW-1:0] held_ext;
  logic          room;
  logic          in_xfer;
  logic          issue;
  logic          scan_done;
  logic          out_free;
  logic          commit;
  logic          in_ready_c;
  logic          spans_ok;

  assign maxc_ext = CW'(max_count_r);
  assign cap      = (maxc_ext > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : maxc_ext;
  assign room     = CW'(held_r) < cap;

  assign in_xfer   = in_if.valid && in_if.ready;
  assign issue     = (state_r == bsst_pkg::ST_SCAN) && (scan_idx_r < held_r);
  assign scan_done = !issue && !rd_vld_r && !gap_vld_r;
  assign out_free  = !out_valid_r || out_if.ready;
  assign commit    = (state_r == bsst_pkg::ST_FINISH) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsst_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (room && (held_r != '0)) begin
            state_nxt = bsst_pkg::ST_SCAN;
          end else begin
            state_nxt = bsst_pkg::ST_FINISH;
          end
        end
      end
      bsst_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = bsst_pkg::ST_FINISH;
        end
      end
      bsst_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = bsst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bsst_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready_c = 1'b0;
    case (state_r)
      bsst_pkg::ST_IDLE:   in_ready_c = 1'b1;
      bsst_pkg::ST_SCAN:   in_ready_c = 1'b0;
      bsst_pkg::ST_FINISH: in_ready_c = 1'b0;
      default:             in_ready_c = 1'b0;
    endcase
  end

  assign in_if.ready  = in_ready_c;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // state update for the item being committed
  always_comb begin
    held_nxt     = held_r;
    least_nxt    = least_r;
    greatest_nxt = greatest_r;
    if (acc_r) begin
      held_nxt = held_r + CNT_W'(1);
      if (held_r == '0) begin
        least_nxt    = val_r;
        greatest_nxt = val_r;
      end else begin
        if ($signed(val_r) < $signed(least_r)) begin
          least_nxt = val_r;
        end
        if ($signed(greatest_r) < $signed(val_r)) begin
          greatest_nxt = val_r;
        end
      end
    end
  end

  assign held_ext = CW'(held_nxt);
  assign spans_ok = held_nxt >= CNT_W'(2);

  always_comb begin
    out_data_nxt.accepted      = acc_r;
    out_data_nxt.stored_count  = held_ext[bsst_pkg::COUNT_W-1:0];
    out_data_nxt.spans_valid   = spans_ok;
    out_data_nxt.shortest_span = spans_ok ? closest_r : '0;
    out_data_nxt.longest_span  = spans_ok ? (greatest_nxt - least_nxt) : '0;
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (commit && acc_r) begin
      store_mem[held_r[AW-1:0]] <= val_r;
    end
    if (issue) begin
      rdata_r <= store_mem[scan_idx_r[AW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      val_r <= in_if.data.value;
    end
    if (rd_vld_r) begin
      gap_r <= bsst_pkg::abs_gap(val_r, rdata_r);
    end
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsst_pkg::ST_IDLE;
      max_count_r <= '0;
      held_r      <= '0;
      least_r     <= '0;
      greatest_r  <= '0;
      closest_r   <= '1;
      acc_r       <= 1'b0;
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      gap_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= issue;
      gap_vld_r <= rd_vld_r;
      if (cfg_if.valid) begin
        max_count_r <= cfg_if.data.max_count;
      end
      if (in_xfer) begin
        acc_r      <= room;
        scan_idx_r <= '0;
      end else if (issue) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end
      if (gap_vld_r && (gap_r < closest_r)) begin
        closest_r <= gap_r;
      end
      if (commit) begin
        held_r      <= held_nxt;
        least_r     <= least_nxt;
        greatest_r  <= greatest_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `BSST_ASSERT_NOW(a_count_bound, 1'b1, CW'(held_r) <= CW'(MAX_ENTRIES), "count beyond store")
  `BSST_ASSERT_NOW(a_span_order, out_if.valid && out_if.data.spans_valid, out_if.data.longest_span >= out_if.data.shortest_span, "shortest span above longest span")
  `BSST_ASSERT_NEXT(a_one_item, in_if.valid && in_if.ready, !in_if.ready, "second item taken during work")
  `BSST_ASSERT_NOW(a_scan_quiet, state_r == bsst_pkg::ST_IDLE, !rd_vld_r && !gap_vld_r, "scan pipeline busy while idle")

endmodule

### dv/span_checker.sv
`timescale 1ns / 1ps
// Result checker for bounded_set_span_tracker_unit: tracks the capacity,
// predicts one result per input transfer and compares each result transfer.
// Depends on bsst_pkg for the payload types.
module span_checker #(
  parameter int unsigned DEPTH = bsst_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bsst_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bsst_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  bsst_pkg::cfg_item_t cfg_data,
  output int                  mismatches,
  output int                  outstanding
);

  logic signed [bsst_pkg::VALUE_W-1:0] held_numbers [DEPTH];
  int unsigned                         held_total;
  logic signed [bsst_pkg::VALUE_W-1:0] least_num;
  logic signed [bsst_pkg::VALUE_W-1:0] greatest_num;
  logic [bsst_pkg::VALUE_W-1:0]        nearest_gap;
  logic [bsst_pkg::COUNT_W-1:0]        capacity;
  bsst_pkg::out_item_t                 expected_spans [$];
  int                                  fault_total = 0;

  function automatic bsst_pkg::out_item_t track_number(
    input logic signed [bsst_pkg::VALUE_W-1:0] v
  );
    bsst_pkg::out_item_t          r;
    int unsigned                  room;
    int unsigned                  i;
    logic [bsst_pkg::VALUE_W-1:0] d;
    room = (capacity > DEPTH) ? DEPTH : capacity;
    r = '0;
    if (held_total < room) begin
      r.accepted = 1'b1;
      for (i = 0; i < held_total; i++) begin
        d = (v < held_numbers[i]) ? held_numbers[i] - v : v - held_numbers[i];
        if (d < nearest_gap) begin
          nearest_gap = d;
        end
      end
      if (held_total == 0) begin
        least_num    = v;
        greatest_num = v;
      end else begin
        if (v < least_num) begin
          least_num = v;
        end
        if (v > greatest_num) begin
          greatest_num = v;
        end
      end
      held_numbers[held_total] = v;
      held_total++;
    end
    r.stored_count = bsst_pkg::COUNT_W'(held_total);
    r.spans_valid  = (held_total >= 2);
    if (r.spans_valid) begin
      r.shortest_span = nearest_gap;
      r.longest_span  = greatest_num - least_num;
    end
    return r;
  endfunction

  function automatic void compare_field(input string name,
                                        input logic [bsst_pkg::VALUE_W-1:0] want,
                                        input logic [bsst_pkg::VALUE_W-1:0] got);
    if (want !== got) begin
      fault_total++;
      if (fault_total <= 10) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    bsst_pkg::out_item_t want;
    if (!rst_n) begin
      held_total   = 0;
      least_num    = '0;
      greatest_num = '0;
      nearest_gap  = '1;
      capacity     = '0;
      expected_spans.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_data.max_count;
      end
      if (in_valid && in_ready) begin
        expected_spans = {expected_spans, track_number(in_data.value)};
      end
      if (out_valid && out_ready) begin
        if (expected_spans.size() == 0) begin
          fault_total++;
          if (fault_total <= 10) begin
            $display("%0t: result transfer with nothing expected, actual 0x%0h",
                     $time, out_data);
          end
        end else begin
          want = expected_spans.pop_front();
          compare_field("accepted", want.accepted, out_data.accepted);
          compare_field("stored_count", want.stored_count, out_data.stored_count);
          compare_field("spans_valid", want.spans_valid, out_data.spans_valid);
          compare_field("shortest_span", want.shortest_span, out_data.shortest_span);
          compare_field("longest_span", want.longest_span, out_data.longest_span);
        end
      end
    end
    mismatches  <= fault_total;
    outstanding <= expected_spans.size();
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the span tracker bench: clock, reset, capacity writes, number stimulus
// with random idling on both channels, and the verdict.
// Depends on bsst_pkg, bsst_chan_if, span_checker and bounded_set_span_tracker_unit.
module tb_top;

  localparam int unsigned RUN_LIMIT    = 4_000_000;
  localparam int unsigned RANDOM_ITEMS = 580;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_WAIT   = 20;
  localparam int unsigned CAP_TOP      = (1 << bsst_pkg::COUNT_W) - 1;

  logic clk;
  logic rst_n;

  bsst_chan_if #(.data_t(bsst_pkg::in_item_t))  in_ch ();
  bsst_chan_if #(.data_t(bsst_pkg::out_item_t)) out_ch ();
  bsst_chan_if #(.data_t(bsst_pkg::cfg_item_t)) cfg_ch ();

  int                                  mismatches;
  int                                  outstanding;
  int unsigned                         cycle_count = 0;
  int unsigned                         hold_asks = 0;
  bit                                  send_quiet;
  logic signed [bsst_pkg::VALUE_W-1:0] recent_numbers [$];
  logic signed [bsst_pkg::VALUE_W-1:0] cluster_base;
  int unsigned                         fill_bound;

  bounded_set_span_tracker_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  span_checker u_span_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data     (in_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_data    (out_ch.data),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_data    (cfg_ch.data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [bsst_pkg::VALUE_W-1:0] pick_number();
    logic signed [bsst_pkg::VALUE_W-1:0] v;
    logic [bsst_pkg::VALUE_W-1:0]        bit_mark;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh7FFFFFFF;
          1:       v = 32'sh80000000;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      3: begin
        if (recent_numbers.size() != 0) begin
          v = recent_numbers[$urandom_range(0, recent_numbers.size() - 1)];
        end else begin
          v = $urandom;
        end
      end
      4: begin
        bit_mark = 32'h1 << $urandom_range(0, 31);
        v = $urandom_range(0, 1) ? bit_mark : ~bit_mark;
      end
      default: v = cluster_base + $urandom_range(0, 200) - 100;
    endcase
    return v;
  endfunction

  task automatic send_number(input logic signed [bsst_pkg::VALUE_W-1:0] v);
    int unsigned gap;
    gap = pick_gap(send_quiet);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    recent_numbers = {recent_numbers, v};
    if (recent_numbers.size() > 32) begin
      void'(recent_numbers.pop_front());
    end
  endtask

  task automatic send_numbers(input int unsigned n);
    repeat (n) send_number(pick_number());
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_capacity(input int unsigned cap);
    wait_drained();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.data.max_count <= bsst_pkg::COUNT_W'(cap);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // receiver: random stalls, quiet stretches, and a long hold-off on request
  initial begin
    int unsigned stall;
    int unsigned holds_done;
    bit          recv_quiet;
    recv_quiet = 1'b0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    repeat (12) @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) begin
        recv_quiet = !recv_quiet;
      end
      if (hold_asks != holds_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done = hold_asks;
      end else begin
        stall = pick_gap(recv_quiet);
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned cap;
    int unsigned kind;
    int unsigned phase;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    send_quiet   = 1'b0;
    cluster_base = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero capacity refuses everything
    write_capacity(0);
    send_number(32'sh7FFFFFFF);
    send_number(32'sh80000000);
    // single number: spans stay invalid, then the store is full
    write_capacity(1);
    send_number(32'sh80000000);
    send_number('0);
    // full-scale span, repeated number, fill to capacity and refuse
    write_capacity(5);
    send_number(32'sh7FFFFFFF);
    send_number(32'sh7FFFFFFF);
    send_number('1);
    send_number(32'sd1);
    send_number(32'sd2);
    // capacity below the count keeps refusing
    write_capacity(3);
    send_number(32'sd3);
    send_number(-32'sd4);
    // capacity above the store depth saturates
    write_capacity(CAP_TOP);
    send_number(32'sh55555555);
    send_number(32'shAAAAAAAA);
    write_capacity(bsst_pkg::MAX_ENTRIES_DEF);
    send_number(32'sh00010000);
    fill_bound = 8;

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        cap = $urandom_range(0, fill_bound);
        n   = $urandom_range(5, 15);
      end else if (kind == 1) begin
        cap = $urandom_range(bsst_pkg::MAX_ENTRIES_DEF, CAP_TOP);
        n   = $urandom_range(3, 10);
      end else begin
        cap = fill_bound + $urandom_range(1, 25);
        if (cap > bsst_pkg::MAX_ENTRIES_DEF) begin
          cap = bsst_pkg::MAX_ENTRIES_DEF;
        end
        n = $urandom_range(10, 40);
      end
      write_capacity(cap);
      if (cap > fill_bound) begin
        fill_bound = (cap < fill_bound + n) ? cap : fill_bound + n;
      end
      cluster_base = $urandom;
      send_quiet   = ($urandom_range(0, 3) == 0);
      if (phase == 2 || phase == 9) begin
        hold_asks++;
      end
      send_numbers(n);
      sent += n;
      phase++;
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### bounded_set_span_tracker_unit.f
+incdir+design
design/bsst_pkg.sv
design/bsst_chan_if.sv
design/bounded_set_span_tracker_unit.sv
dv/span_checker.sv
dv/tb_top.sv
